@@ src/pim_pkg.sv @@
package pim_pkg;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 32;

    localparam logic [CfgIndexW-1:0] REG_FOCAL_X       = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_FOCAL_Y       = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_SKEW          = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_CENTER_X      = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_CENTER_Y      = 3'd4;
    localparam logic [CfgIndexW-1:0] REG_RECIP_FOCAL_X = 3'd5;
    localparam logic [CfgIndexW-1:0] REG_RECIP_FOCAL_Y = 3'd6;
    localparam logic [CfgIndexW-1:0] REG_MIN_DEPTH     = 3'd7;

    // divider: 4 quotient bits per stage over a 36-bit dividend
    localparam int DivBits   = 4;
    localparam int DivNumW   = 36;
    localparam int DivStages = DivNumW / DivBits;
    // norm pipe has 6 stages, reciprocal pipe 1 + DivStages + 1
    localparam int NormStages = 6;
    localparam int AlignDepth = DivStages + 2 - NormStages;
    localparam int NumOut     = 12;

    typedef struct packed {
        logic valid;
        logic skip;
    } pim_ctl_t;

    function automatic logic signed [63:0] rshift(input logic signed [63:0] v, input int n);
        logic signed [63:0] half;
        half = 64'sd1 <<< (n - 1);
        return (v + half) >>> n;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ src/pim_recip.sv @@
module pim_recip
    import pim_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [23:0]  depth,
    input  logic [22:0]         min_depth,
    output pim_ctl_t            ctl,
    output logic signed [31:0]  inv
);

    logic [23:0] mag;
    logic        skip;

    pim_ctl_t           ctl_reg  [DivStages+1];
    logic               neg_reg  [DivStages+1];
    logic [23:0]        den_reg  [DivStages+1];
    logic [24:0]        rem_reg  [DivStages+1];
    logic [DivNumW-1:0] num_reg  [DivStages+1];
    logic [DivNumW-1:0] quo_reg  [DivStages+1];
    pim_ctl_t           ctl_out_reg;
    logic signed [31:0] inv_reg;
    logic signed [31:0] inv_next;

    typedef struct packed {
        logic [24:0]        rem;
        logic [DivNumW-1:0] num;
        logic [DivNumW-1:0] quo;
    } div_state_t;

    function automatic div_state_t div_step(input div_state_t s, input logic [23:0] d);
        div_state_t r;
        r = s;
        for (int i = 0; i < DivBits; i++) begin
            r.rem = {r.rem[23:0], r.num[DivNumW-1]};
            r.num = {r.num[DivNumW-2:0], 1'b0};
            if (r.rem >= {1'b0, d}) begin
                r.rem = r.rem - {1'b0, d};
                r.quo = {r.quo[DivNumW-2:0], 1'b1};
            end
            else begin
                r.quo = {r.quo[DivNumW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    assign mag  = depth[23] ? 24'(-depth) : 24'(depth);
    assign skip = (depth == 24'sd0) || (mag < {1'b0, min_depth});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k <= DivStages; k++)
                ctl_reg[k] <= '0;
            ctl_out_reg <= '0;
        end
        else begin
            ctl_reg[0] <= '{valid: in_valid, skip: skip};
            for (int k = 1; k <= DivStages; k++)
                ctl_reg[k] <= ctl_reg[k-1];
            ctl_out_reg <= ctl_reg[DivStages];
        end
    end

    // dividend is 2^32 + mag/2 so the quotient rounds half away from zero
    always_ff @(posedge clk) begin
        neg_reg[0] <= depth[23];
        den_reg[0] <= mag;
        rem_reg[0] <= '0;
        num_reg[0] <= 36'h1_0000_0000 + 36'(mag >> 1);
        quo_reg[0] <= '0;
        for (int k = 1; k <= DivStages; k++) begin
            div_state_t st;
            st = div_step('{rem: rem_reg[k-1], num: num_reg[k-1], quo: quo_reg[k-1]},
                          den_reg[k-1]);
            neg_reg[k] <= neg_reg[k-1];
            den_reg[k] <= den_reg[k-1];
            rem_reg[k] <= st.rem;
            num_reg[k] <= st.num;
            quo_reg[k] <= st.quo;
        end
        inv_reg <= inv_next;
    end

    always_comb begin
        logic [DivNumW-1:0] q;
        q = quo_reg[DivStages];
        if (!neg_reg[DivStages])
            inv_next = (q > 36'd2147483647) ? 32'sh7fffffff : $signed(q[31:0]);
        else
            inv_next = (q >= 36'd2147483648) ? 32'sh80000000 : $signed(-q[31:0]);
    end

    assign ctl = ctl_out_reg;
    assign inv = inv_reg;

endmodule

@@ src/pim_norm.sv @@
module pim_norm
    import pim_pkg::*;
(
    input  logic                clk,
    input  logic [15:0]         u_coord,
    input  logic [15:0]         v_coord,
    input  logic [15:0]         center_x,
    input  logic [15:0]         center_y,
    input  logic signed [23:0]  skew,
    input  logic [31:0]         recip_focal_x,
    input  logic [31:0]         recip_focal_y,
    output logic signed [31:0]  x,
    output logic signed [31:0]  y
);

    logic signed [16:0] du;
    logic signed [16:0] dv;
    logic signed [16:0] du1_reg, du2_reg, du3_reg;
    logic signed [63:0] dvp_reg;
    logic signed [63:0] skp_reg;
    logic signed [63:0] wp_reg;
    logic signed [31:0] y2_reg, y3_reg, y4_reg, y5_reg, y6_reg;
    logic signed [31:0] w_reg;
    logic signed [31:0] x_reg;
    logic signed [63:0] w_next;

    assign du = $signed({1'b0, u_coord}) - $signed({1'b0, center_x});
    assign dv = $signed({1'b0, v_coord}) - $signed({1'b0, center_y});

    assign w_next = 64'($signed({du3_reg, 12'd0})) - 64'(sat32(rshift(skp_reg, 12)));

    always_ff @(posedge clk) begin
        dvp_reg <= 64'(dv) * 64'($signed({1'b0, recip_focal_y}));
        du1_reg <= du;
        y2_reg  <= sat32(rshift(dvp_reg, 12));
        du2_reg <= du1_reg;
        skp_reg <= 64'(skew) * 64'(y2_reg);
        y3_reg  <= y2_reg;
        du3_reg <= du2_reg;
        w_reg   <= sat32(w_next);
        y4_reg  <= y3_reg;
        wp_reg  <= 64'(w_reg) * 64'($signed({1'b0, recip_focal_x}));
        y5_reg  <= y4_reg;
        x_reg   <= sat32(rshift(wp_reg, 24));
        y6_reg  <= y5_reg;
    end

    assign x = x_reg;
    assign y = y6_reg;

endmodule

@@ src/pim_jac.sv @@
module pim_jac
    import pim_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  pim_ctl_t            in_ctl,
    input  logic signed [31:0]  x,
    input  logic signed [31:0]  y,
    input  logic signed [31:0]  inv,
    input  logic [23:0]         focal_x,
    input  logic [23:0]         focal_y,
    input  logic signed [23:0]  skew,
    output logic                done,
    output logic signed [31:0]  res [NumOut]
);

    pim_ctl_t           ctl1_reg, ctl2_reg, ctl3_reg;
    logic               done_reg;
    logic signed [63:0] pxi_reg, pxy_reg, pxx_reg, pyi_reg, pyy_reg;
    logic signed [31:0] x1_reg, y1_reg, inv1_reg;
    logic signed [31:0] j0_reg [6];
    logic signed [31:0] j1_reg [6];
    logic signed [63:0] m0_reg [6];
    logic signed [63:0] m1_reg [6];
    logic signed [63:0] m2_reg [6];
    logic signed [31:0] res_reg [NumOut];
    logic signed [63:0] xy;
    logic signed [63:0] neg_inv;

    assign xy      = rshift(pxy_reg, 16);
    assign neg_inv = -64'(inv1_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            done_reg <= 1'b0;
        end
        else begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            done_reg <= ctl3_reg.valid;
        end
    end

    always_ff @(posedge clk) begin
        pxi_reg  <= 64'(x) * 64'(inv);
        pxy_reg  <= 64'(x) * 64'(y);
        pxx_reg  <= 64'(x) * 64'(x);
        pyi_reg  <= 64'(y) * 64'(inv);
        pyy_reg  <= 64'(y) * 64'(y);
        x1_reg   <= x;
        y1_reg   <= y;
        inv1_reg <= inv;

        j0_reg[0] <= sat32(neg_inv);
        j0_reg[1] <= '0;
        j0_reg[2] <= sat32(rshift(pxi_reg, 16));
        j0_reg[3] <= sat32(xy);
        j0_reg[4] <= sat32(-(64'sd65536 + rshift(pxx_reg, 16)));
        j0_reg[5] <= y1_reg;
        j1_reg[0] <= '0;
        j1_reg[1] <= sat32(neg_inv);
        j1_reg[2] <= sat32(rshift(pyi_reg, 16));
        j1_reg[3] <= sat32(64'sd65536 + rshift(pyy_reg, 16));
        j1_reg[4] <= sat32(-xy);
        j1_reg[5] <= sat32(-64'(x1_reg));

        for (int k = 0; k < 6; k++) begin
            m0_reg[k] <= 64'($signed({1'b0, focal_x})) * 64'(j0_reg[k]);
            m1_reg[k] <= 64'(skew) * 64'(j1_reg[k]);
            m2_reg[k] <= 64'($signed({1'b0, focal_y})) * 64'(j1_reg[k]);
        end

        // shallow points drop to all-zero rows
        for (int k = 0; k < 6; k++) begin
            res_reg[k]     <= ctl3_reg.skip ? '0 : sat32(rshift(m0_reg[k] + m1_reg[k], 12));
            res_reg[6 + k] <= ctl3_reg.skip ? '0 : sat32(rshift(m2_reg[k], 12));
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ src/point_interaction_matrix.sv @@
// Point interaction matrix: one image point in, twelve Jacobian entries out.
// Throughput: one point per cycle; busy stays low, the pipeline never stalls.
// The result strobe follows the start transfer through the reciprocal's input stage,
// 9 divider stages of 4 bits and saturation, then through 4 stages of products.
// Reset clears the configuration to its defaults and drops all in-flight points.
module point_interaction_matrix
    import pim_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [15:0]          u_coord,
    input  logic [15:0]          v_coord,
    input  logic signed [23:0]   depth,
    output logic                 done,
    output logic signed [31:0]   row0_tx,
    output logic signed [31:0]   row0_ty,
    output logic signed [31:0]   row0_tz,
    output logic signed [31:0]   row0_rx,
    output logic signed [31:0]   row0_ry,
    output logic signed [31:0]   row0_rz,
    output logic signed [31:0]   row1_tx,
    output logic signed [31:0]   row1_ty,
    output logic signed [31:0]   row1_tz,
    output logic signed [31:0]   row1_rx,
    output logic signed [31:0]   row1_ry,
    output logic signed [31:0]   row1_rz
);

    logic [23:0]        focal_x_reg;
    logic [23:0]        focal_y_reg;
    logic signed [23:0] skew_reg;
    logic [15:0]        center_x_reg;
    logic [15:0]        center_y_reg;
    logic [31:0]        recip_focal_x_reg;
    logic [31:0]        recip_focal_y_reg;
    logic [22:0]        min_depth_reg;

    pim_ctl_t           div_ctl;
    logic signed [31:0] inv;
    logic signed [31:0] norm_x, norm_y;
    logic signed [31:0] x_dly_reg [AlignDepth];
    logic signed [31:0] y_dly_reg [AlignDepth];
    logic signed [31:0] res [NumOut];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            focal_x_reg       <= 24'd4096;
            focal_y_reg       <= 24'd4096;
            skew_reg          <= '0;
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            recip_focal_x_reg <= 32'd16777216;
            recip_focal_y_reg <= 32'd16777216;
            min_depth_reg     <= 23'd66;
        end
        else if (cfg_we) begin
            case (cfg_index)
                REG_FOCAL_X:       focal_x_reg       <= cfg_data[23:0];
                REG_FOCAL_Y:       focal_y_reg       <= cfg_data[23:0];
                REG_SKEW:          skew_reg          <= $signed(cfg_data[23:0]);
                REG_CENTER_X:      center_x_reg      <= cfg_data[15:0];
                REG_CENTER_Y:      center_y_reg      <= cfg_data[15:0];
                REG_RECIP_FOCAL_X: recip_focal_x_reg <= cfg_data;
                REG_RECIP_FOCAL_Y: recip_focal_y_reg <= cfg_data;
                REG_MIN_DEPTH:     min_depth_reg     <= cfg_data[22:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    pim_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .depth     (depth),
        .min_depth (min_depth_reg),
        .ctl       (div_ctl),
        .inv       (inv)
    );

    pim_norm u_norm (
        .clk           (clk),
        .u_coord       (u_coord),
        .v_coord       (v_coord),
        .center_x      (center_x_reg),
        .center_y      (center_y_reg),
        .skew          (skew_reg),
        .recip_focal_x (recip_focal_x_reg),
        .recip_focal_y (recip_focal_y_reg),
        .x             (norm_x),
        .y             (norm_y)
    );

    // hold x, y until the reciprocal catches up
    always_ff @(posedge clk) begin
        x_dly_reg[0] <= norm_x;
        y_dly_reg[0] <= norm_y;
        for (int k = 1; k < AlignDepth; k++) begin
            x_dly_reg[k] <= x_dly_reg[k-1];
            y_dly_reg[k] <= y_dly_reg[k-1];
        end
    end

    pim_jac u_jac (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (div_ctl),
        .x       (x_dly_reg[AlignDepth-1]),
        .y       (y_dly_reg[AlignDepth-1]),
        .inv     (inv),
        .focal_x (focal_x_reg),
        .focal_y (focal_y_reg),
        .skew    (skew_reg),
        .done    (done),
        .res     (res)
    );

    assign row0_tx = res[0];
    assign row0_ty = res[1];
    assign row0_tz = res[2];
    assign row0_rx = res[3];
    assign row0_ry = res[4];
    assign row0_rz = res[5];
    assign row1_tx = res[6];
    assign row1_ty = res[7];
    assign row1_tz = res[8];
    assign row1_rx = res[9];
    assign row1_ry = res[10];
    assign row1_rz = res[11];

endmodule

@@ src/pim_checker.sv @@
module pim_checker
    import pim_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_we,
    input logic [CfgIndexW-1:0] cfg_index,
    input logic [CfgDataW-1:0]  cfg_data,
    input logic                 start,
    input logic                 busy,
    input logic [15:0]          u_coord,
    input logic [15:0]          v_coord,
    input logic signed [23:0]   depth,
    input logic                 done,
    input logic signed [31:0]   row0_tx,
    input logic signed [31:0]   row0_ty,
    input logic signed [31:0]   row0_tz,
    input logic signed [31:0]   row0_rx,
    input logic signed [31:0]   row0_ry,
    input logic signed [31:0]   row0_rz,
    input logic signed [31:0]   row1_tx,
    input logic signed [31:0]   row1_ty,
    input logic signed [31:0]   row1_tz,
    input logic signed [31:0]   row1_rx,
    input logic signed [31:0]   row1_ry,
    input logic signed [31:0]   row1_rz
);

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##15 done)
        else $error("result missing");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 15))
        else $error("result without transfer");

    // second row has no x translation term
    a_row1_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> row1_tx == 32'sd0)
        else $error("row1_tx nonzero");

    a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && depth == 24'sd0 |-> ##15 (row0_tx == 32'sd0 && row1_rz == 32'sd0))
        else $error("zero depth not skipped");

endmodule

bind point_interaction_matrix pim_checker u_pim_checker (.*);

@@ tb/sv/tb_point_interaction_matrix.sv @@
module tb_point_interaction_matrix;
    timeunit 1ns;
    timeprecision 1ps;

    import pim_pkg::*;

    typedef enum logic {ITEM_POINT, ITEM_CFG} item_kind_t;

    typedef struct {
        item_kind_t            kind;
        logic [15:0]           u;
        logic [15:0]           v;
        logic signed [23:0]    z;
        logic [CfgIndexW-1:0]  idx;
        logic [CfgDataW-1:0]   data;
    } work_item_t;

    typedef logic [NumOut*32-1:0] jac_t;

    localparam int DrainCycles = 20;
    localparam int IdleLimit   = 5000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;
    logic                 start;
    logic                 busy;
    logic [15:0]          u_coord;
    logic [15:0]          v_coord;
    logic signed [23:0]   depth;
    logic                 done;
    logic signed [31:0]   row0_tx, row0_ty, row0_tz, row0_rx, row0_ry, row0_rz;
    logic signed [31:0]   row1_tx, row1_ty, row1_tz, row1_rx, row1_ry, row1_rz;

    work_item_t pending_items[$];
    jac_t       expected_rows[$];
    int         mismatches = 0;

    // shadow copy of the configuration
    longint m_fx, m_fy, m_skew, m_cx, m_cy, m_rfx, m_rfy, m_min_depth;

    point_interaction_matrix i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .u_coord(u_coord), .v_coord(v_coord), .depth(depth),
        .done(done),
        .row0_tx(row0_tx), .row0_ty(row0_ty), .row0_tz(row0_tz),
        .row0_rx(row0_rx), .row0_ry(row0_ry), .row0_rz(row0_rz),
        .row1_tx(row1_tx), .row1_ty(row1_ty), .row1_tz(row1_tz),
        .row1_rx(row1_rx), .row1_ry(row1_ry), .row1_rz(row1_rz)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint round_q(input longint val, input int n);
        return (val + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp32(input longint val);
        if (val > 64'sd2147483647)
            return 64'sd2147483647;
        if (val < -64'sd2147483648)
            return -64'sd2147483648;
        return val;
    endfunction

    task automatic apply_cfg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
        case (idx)
            REG_FOCAL_X:       m_fx = longint'(data[23:0]);
            REG_FOCAL_Y:       m_fy = longint'(data[23:0]);
            REG_SKEW:          m_skew = longint'($signed(data[23:0]));
            REG_CENTER_X:      m_cx = longint'(data[15:0]);
            REG_CENTER_Y:      m_cy = longint'(data[15:0]);
            REG_RECIP_FOCAL_X: m_rfx = longint'(data[31:0]);
            REG_RECIP_FOCAL_Y: m_rfy = longint'(data[31:0]);
            REG_MIN_DEPTH:     m_min_depth = longint'(data[22:0]);
            default: ;
        endcase
    endtask

    function automatic jac_t point_jacobian(input logic [15:0] u, input logic [15:0] v,
                                            input logic signed [23:0] z);
        longint zz, mag, du, dv, x, y, t, w, q, inv, xy;
        longint j0[6];
        longint j1[6];
        jac_t   res;
        zz = longint'(z);
        mag = (zz < 0) ? -zz : zz;
        res = '0;
        if (zz == 0 || mag < m_min_depth)
            return res;
        du = longint'(u) - m_cx;
        dv = longint'(v) - m_cy;
        y = clamp32(round_q(dv * m_rfy, 12));
        t = clamp32(round_q(m_skew * y, 12));
        w = clamp32(du * 4096 - t);
        x = clamp32(round_q(w * m_rfx, 24));
        q = ((64'sd1 <<< 32) + mag / 2) / mag;
        inv = clamp32((zz < 0) ? -q : q);
        xy = round_q(x * y, 16);
        j0[0] = clamp32(-inv);
        j0[1] = 0;
        j0[2] = clamp32(round_q(x * inv, 16));
        j0[3] = clamp32(xy);
        j0[4] = clamp32(-(65536 + round_q(x * x, 16)));
        j0[5] = y;
        j1[0] = 0;
        j1[1] = clamp32(-inv);
        j1[2] = clamp32(round_q(y * inv, 16));
        j1[3] = clamp32(65536 + round_q(y * y, 16));
        j1[4] = clamp32(-xy);
        j1[5] = clamp32(-x);
        for (int k = 0; k < 6; k++)
        begin
            res[k*32 +: 32] = 32'(clamp32(round_q(m_fx * j0[k] + m_skew * j1[k], 12)));
            res[(6+k)*32 +: 32] = 32'(clamp32(round_q(m_fy * j1[k], 12)));
        end
        return res;
    endfunction

    // driver
    int  gap_left;
    int  quiet_cycles;
    int  burst_left;
    bit  burst_mode;

    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_we <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            u_coord <= '0;
            v_coord <= '0;
            depth <= '0;
            gap_left = 0;
            quiet_cycles = 0;
            burst_left = 100;
            burst_mode = 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_rows.push_back(point_jacobian(u_coord, v_coord, depth));
                if (--burst_left == 0)
                begin
                    burst_left = $urandom_range(50, 150);
                    burst_mode = ~burst_mode;
                end
            end
            quiet_cycles = (expected_rows.size() == 0) ? quiet_cycles + 1 : 0;

            if (start && busy)
            begin
                // hold the item until the block takes it
                cfg_we <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
                cfg_we <= 1'b0;
            end
            else if (pending_items.size() != 0 && pending_items[0].kind == ITEM_POINT)
            begin
                u_coord <= pending_items[0].u;
                v_coord <= pending_items[0].v;
                depth <= pending_items[0].z;
                start <= 1'b1;
                cfg_we <= 1'b0;
                void'(pending_items.pop_front());
                gap_left = pick_gap(burst_mode);
            end
            else if (pending_items.size() != 0 && !start && quiet_cycles >= DrainCycles)
            begin
                cfg_we <= 1'b1;
                cfg_index <= pending_items[0].idx;
                cfg_data <= pending_items[0].data;
                apply_cfg(pending_items[0].idx, pending_items[0].data);
                void'(pending_items.pop_front());
            end
            else
            begin
                start <= 1'b0;
                cfg_we <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        jac_t got, want;
        if (rst_n && done)
        begin
            got = {row1_rz, row1_ry, row1_rx, row1_tz, row1_ty, row1_tx,
                   row0_rz, row0_ry, row0_rx, row0_tz, row0_ty, row0_tx};
            if (expected_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t", $realtime);
            end
            else
            begin
                want = expected_rows.pop_front();
                for (int k = 0; k < NumOut; k++)
                begin
                    if (got[k*32 +: 32] !== want[k*32 +: 32])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("entry %0d mismatch: expected %0d actual %0d", k,
                                     $signed(want[k*32 +: 32]), $signed(got[k*32 +: 32]));
                    end
                end
            end
        end
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_we)
                idle_cycles = 0;
            else if (++idle_cycles >= IdleLimit)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic add_cfg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val,
                           input int width);
        work_item_t it;
        logic [CfgDataW-1:0] mask;
        mask = (width >= 32) ? '1 : ((32'd1 << width) - 1);
        it.kind = ITEM_CFG;
        it.idx = idx;
        // toggle the unused upper bits too
        it.data = ($urandom & ~mask) | (val & mask);
        it.u = '0;
        it.v = '0;
        it.z = '0;
        pending_items.push_back(it);
    endtask

    task automatic add_point(input logic [15:0] u, input logic [15:0] v,
                             input logic signed [23:0] z);
        work_item_t it;
        it.kind = ITEM_POINT;
        it.u = u;
        it.v = v;
        it.z = z;
        it.idx = '0;
        it.data = '0;
        pending_items.push_back(it);
    endtask

    task automatic add_all_cfg(input logic [31:0] fx, input logic [31:0] fy,
                               input logic [31:0] sk, input logic [31:0] cx,
                               input logic [31:0] cy, input logic [31:0] rfx,
                               input logic [31:0] rfy, input logic [31:0] md);
        add_cfg(REG_FOCAL_X, fx, 24);
        add_cfg(REG_FOCAL_Y, fy, 24);
        add_cfg(REG_SKEW, sk, 24);
        add_cfg(REG_CENTER_X, cx, 16);
        add_cfg(REG_CENTER_Y, cy, 16);
        add_cfg(REG_RECIP_FOCAL_X, rfx, 32);
        add_cfg(REG_RECIP_FOCAL_Y, rfy, 32);
        add_cfg(REG_MIN_DEPTH, md, 23);
    endtask

    function automatic logic signed [23:0] random_depth(input longint md);
        int r;
        longint m;
        r = $urandom_range(0, 99);
        if (r < 60)
            m = $urandom_range(16, 24'h7fffff);
        else if (r < 80)
            m = md + $urandom_range(0, 6) - 3;
        else
            return 24'($urandom);
        if (m < 0)
            m = 0;
        if (m > 24'h7fffff)
            m = 24'h7fffff;
        return $urandom_range(0, 1) ? -24'(m) : 24'(m);
    endfunction

    task automatic add_random_points(input int n, input longint md);
        for (int i = 0; i < n; i++)
            add_point(16'($urandom), 16'($urandom), random_depth(md));
    endtask

    initial
    begin
        int fx, fy, md;
        m_fx = 4096; m_fy = 4096; m_skew = 0; m_cx = 0; m_cy = 0;
        m_rfx = 16777216; m_rfy = 16777216; m_min_depth = 66;
        rst_n = 1'b0;

        // reset configuration: field extremes and the shallow-point edges
        add_point(16'h0000, 16'h0000, 24'sd65536);
        add_point(16'hffff, 16'hffff, 24'sd65536);
        add_point(16'hffff, 16'h0000, -24'sd65536);
        add_point(16'h0000, 16'hffff, 24'sh7fffff);
        add_point(16'h1234, 16'h4321, 24'sh800000);
        add_point(16'h0100, 16'h0200, 24'sd0);
        add_point(16'h0100, 16'h0200, 24'sd65);
        add_point(16'h0100, 16'h0200, -24'sd65);
        add_point(16'h0100, 16'h0200, 24'sd66);
        add_point(16'h0100, 16'h0200, -24'sd66);
        add_point(16'h0100, 16'h0200, -24'sd1);
        // all registers at their maximum, no depth threshold
        add_all_cfg(32'hffffff, 32'hffffff, 32'h7fffff, 32'hffff, 32'hffff,
                    32'hffffffff, 32'hffffffff, 32'h0);
        add_point(16'h0000, 16'h0000, 24'sd0);
        add_point(16'hffff, 16'hffff, 24'sd1);
        add_point(16'h0000, 16'h0000, -24'sd1);
        add_point(16'h8000, 16'h7fff, 24'sh7fffff);
        add_random_points(20, 0);
        // all registers at their minimum, maximum threshold
        add_all_cfg(32'h0, 32'h0, 32'h800000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7fffff);
        add_point(16'hffff, 16'hffff, 24'sh800000);
        add_point(16'hffff, 16'hffff, 24'sh7fffff);
        add_point(16'h1000, 16'h2000, -24'sh7fffff);
        add_random_points(10, 24'h7fffff);

        for (int phase = 0; phase < 7; phase++)
        begin
            fx = $urandom_range(4096 * 50, 4096 * 2000);
            fy = $urandom_range(4096 * 50, 4096 * 2000);
            md = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23'h7fffff)
                                              : $urandom_range(0, 2000);
            add_all_cfg(fx, fy,
                        ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 8192) - 4096,
                        $urandom, $urandom,
                        ($urandom_range(0, 4) == 0) ? $urandom : 32'((64'd1 << 36) / fx),
                        ($urandom_range(0, 4) == 0) ? $urandom : 32'((64'd1 << 36) / fy),
                        md);
            add_random_points(150, md);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_items.size() != 0 || start || expected_rows.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatches == 0 && expected_rows.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
